// ----- hw/rtl/magnetometer_compass_heading_macros.svh -----
// Assertion helpers for the checker file
`ifndef MAGNETOMETER_COMPASS_HEADING_MACROS_SVH
`define MAGNETOMETER_COMPASS_HEADING_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define MCH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("compass heading check failed");

// Condition that must never be seen outside reset
`define MCH_NEVER(label, clk, rst, cond) \
   `MCH_ASSERT(label, clk, rst, !(cond))

`endif

// ----- hw/rtl/mch_pkg.sv -----
package mch_pkg;

   // Angles in hundredths of a degree
   localparam int FULL_TURN    = 36000;
   localparam int HALF_TURN    = 18000;
   localparam int QUARTER_TURN = 9000;
   localparam int EIGHTH_TURN  = 4500;
   localparam logic signed [15:0] DECL_RESET = 16'sd1282;

   // Normalized vector magnitude reaches at least 2^NORM_BIT
   localparam int NORM_BIT  = 49;
   localparam int ANGLE_W   = 32;
   localparam int TABLE_LEN = 24;

   typedef enum logic [1:0] {
      ACT_SAMPLE      = 2'd0,
      ACT_END_CAL     = 2'd1,
      ACT_SET_NORTH   = 2'd2,
      ACT_RESET_NORTH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_START, ST_ROT, ST_SCALE, ST_SUM, ST_WRAP, ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      C_IDLE, C_NORM, C_ROT
   } cordic_state_type;

   // atan(2^-i) as a binary angle, 2^32 is a full turn
   function automatic logic [ANGLE_W-1:0] atan_step(input logic [4:0] idx);
      logic [ANGLE_W-1:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/mch_req_if.sv -----
interface mch_req_if #(parameter int SAMPLE_BITS = 20);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic signed [SAMPLE_BITS-1:0] mag_x;
   logic signed [SAMPLE_BITS-1:0] mag_y;

   modport source (output valid, action, mag_x, mag_y, input ready);
   modport sink   (input valid, action, mag_x, mag_y, output ready);
endinterface

// ----- hw/rtl/mch_rsp_if.sv -----
interface mch_rsp_if;
   logic               valid;
   logic               ready;
   logic               heading_valid;
   logic [15:0]        heading;
   logic [1:0]         sector;
   logic signed [15:0] north_correction;

   modport source (output valid, heading_valid, heading, sector, north_correction,
                   input ready);
   modport sink   (input valid, heading_valid, heading, sector, north_correction,
                   output ready);
endinterface

// ----- hw/rtl/magnetometer_compass_heading.sv -----
// Compass heading from hard-iron calibrated magnetometer X/Y samples.
// Calibrating: an accepted request goes straight to the output state, where its response is registered.
// Calibrated: shift-add scaling, a start state, normalization shifts, CORDIC_STEPS rotation steps,
// a hand-off state, then scaling to hundredths, the declination sum, the wrap and the output state.
// One request at a time; the next is accepted as soon as the result is registered.
// Synchronous reset: calibration mode, empty min/max, north offset 0, declination 12.82.
module magnetometer_compass_heading
   import mch_pkg::*;
#(
   parameter int SAMPLE_BITS  = 20,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   mch_req_if.sink            req_chan,
   mch_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data
);

   localparam int SB  = SAMPLE_BITS;
   localparam int MW  = SB + 1;
   localparam int MCW = $clog2(MW);
   localparam int CXW = SB + 2;
   localparam int PW  = 2 * SB + 3;
   localparam int CW  = ((PW > 51) ? PW : 51) + 3;
   localparam logic signed [17:0] FULL_S  = 18'(FULL_TURN);
   localparam logic signed [17:0] HALF_S  = 18'(HALF_TURN);

   top_state_type        state_ff, state_in;
   logic                 cal_ff, cal_in;
   logic signed [SB-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [SB-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic signed [15:0]   decl_ff, off_ff, off_in;
   logic [1:0]           action_ff, action_in;
   logic [MCW-1:0]       cnt_ff, cnt_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [PW-1:0] mc_x_ff, mc_x_in, mc_y_ff, mc_y_in;
   logic [MW-1:0]        mp_x_ff, mp_x_in, mp_y_ff, mp_y_in;
   logic [ANGLE_W-1:0]   ang_ff, ang_in;
   logic [15:0]          raw_ff, raw_in;
   logic signed [17:0]   h_ff, h_in;
   logic                 hv_ff, hv_in;
   logic                 rv_ff, rv_in;
   logic                 rhv_ff, rhv_in;
   logic [15:0]          rhdg_ff, rhdg_in;
   logic [1:0]           rsec_ff, rsec_in;
   logic signed [15:0]   rnc_ff, rnc_in;

   logic signed [SB:0]   sx_d, sy_d;
   logic [MW-1:0]        span_x, span_y;
   logic signed [CXW-1:0] cx, cy;
   logic [47:0]          prod;
   logic signed [17:0]   neg_h;
   logic                 c_start, c_done;
   logic [ANGLE_W-1:0]   c_angle;

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rv_ff;
   assign rsp_chan.heading_valid    = rhv_ff;
   assign rsp_chan.heading          = rhdg_ff;
   assign rsp_chan.sector           = rsec_ff;
   assign rsp_chan.north_correction = rnc_ff;

   mch_cordic #(.PW(PW), .CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (c_start),
      .px    (px_ff),
      .py    (py_ff),
      .done  (c_done),
      .angle (c_angle)
   );

   always_comb begin
      // hard-iron offsets and spans from the frozen min/max
      sx_d   = (SB+1)'(max_x_ff) - (SB+1)'(min_x_ff);
      sy_d   = (SB+1)'(max_y_ff) - (SB+1)'(min_y_ff);
      span_x = (sx_d > 0) ? MW'(sx_d) : MW'(1);
      span_y = (sy_d > 0) ? MW'(sy_d) : MW'(1);
      cx = (CXW'(req_chan.mag_x) <<< 1) - (CXW'(max_x_ff) + CXW'(min_x_ff));
      cy = (CXW'(req_chan.mag_y) <<< 1) - (CXW'(max_y_ff) + CXW'(min_y_ff));
      prod  = {16'd0, ang_ff} * 48'(FULL_TURN) + 48'h0000_8000_0000;
      neg_h = -h_ff;

      state_in  = state_ff;
      cal_in    = cal_ff;
      min_x_in  = min_x_ff;
      min_y_in  = min_y_ff;
      max_x_in  = max_x_ff;
      max_y_in  = max_y_ff;
      off_in    = off_ff;
      action_in = action_ff;
      cnt_in    = cnt_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      mc_x_in   = mc_x_ff;
      mc_y_in   = mc_y_ff;
      mp_x_in   = mp_x_ff;
      mp_y_in   = mp_y_ff;
      ang_in    = ang_ff;
      raw_in    = raw_ff;
      h_in      = h_ff;
      hv_in     = hv_ff;
      rv_in     = rv_ff & ~rsp_chan.ready;
      rhv_in    = rhv_ff;
      rhdg_in   = rhdg_ff;
      rsec_in   = rsec_ff;
      rnc_in    = rnc_ff;
      c_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in = req_chan.action;
               if (cal_ff) begin
                  // track extremes, result is an invalid heading
                  if (req_chan.mag_x < min_x_ff) min_x_in = req_chan.mag_x;
                  if (req_chan.mag_y < min_y_ff) min_y_in = req_chan.mag_y;
                  if (req_chan.mag_x > max_x_ff) max_x_in = req_chan.mag_x;
                  if (req_chan.mag_y > max_y_ff) max_y_in = req_chan.mag_y;
                  if (req_chan.action != ACT_SAMPLE) cal_in = 1'b0;
                  hv_in    = 1'b0;
                  h_in     = '0;
                  state_in = ST_OUT;
               end else begin
                  hv_in    = 1'b1;
                  px_in    = '0;
                  py_in    = '0;
                  mc_x_in  = PW'(cy);
                  mp_x_in  = span_x;
                  mc_y_in  = PW'(cx);
                  mp_y_in  = span_y;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         // shift-add scaling, one multiplier bit per cycle
         ST_MUL: begin
            if (mp_x_ff[0]) px_in = px_ff + mc_x_ff;
            if (mp_y_ff[0]) py_in = py_ff + mc_y_ff;
            mc_x_in = mc_x_ff <<< 1;
            mc_y_in = mc_y_ff <<< 1;
            mp_x_in = mp_x_ff >> 1;
            mp_y_in = mp_y_ff >> 1;
            cnt_in  = cnt_ff + MCW'(1);
            if (cnt_ff == MCW'(MW-1)) state_in = ST_START;
         end
         ST_START: begin
            if ((px_ff == '0) && (py_ff == '0)) begin
               ang_in   = '0;
               state_in = ST_SCALE;
            end else begin
               c_start  = 1'b1;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (c_done) begin
               ang_in   = c_angle;
               state_in = ST_SCALE;
            end
         end
         // binary angle to hundredths of a degree, rounded
         ST_SCALE: begin
            raw_in   = prod[47:32];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            h_in = ((raw_ff == 16'(FULL_TURN)) ? 18'sd0 : 18'(raw_ff))
                   + 18'(decl_ff) + 18'(off_ff);
            state_in = ST_WRAP;
         end
         // bring the sum into one turn, one correction per cycle
         ST_WRAP: begin
            if (h_ff < 0)            h_in = h_ff + FULL_S;
            else if (h_ff >= FULL_S) h_in = h_ff - FULL_S;
            else                     state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_chan.ready) begin
               rv_in   = 1'b1;
               rhv_in  = hv_ff;
               rhdg_in = 16'(h_ff);
               if (!hv_ff || h_ff < 18'(EIGHTH_TURN))                 rsec_in = 2'd0;
               else if (h_ff < 18'(EIGHTH_TURN + QUARTER_TURN))       rsec_in = 2'd1;
               else if (h_ff < 18'(EIGHTH_TURN + 2 * QUARTER_TURN))   rsec_in = 2'd2;
               else if (h_ff < 18'(EIGHTH_TURN + 3 * QUARTER_TURN))   rsec_in = 2'd3;
               else                                                   rsec_in = 2'd0;
               rnc_in = off_ff;
               if (hv_ff && action_ff == ACT_SET_NORTH) begin
                  off_in = (neg_h <= -HALF_S) ? 16'(neg_h + FULL_S) : 16'(neg_h);
                  rnc_in = off_in;
               end else if (hv_ff && action_ff == ACT_RESET_NORTH) begin
                  off_in = '0;
                  rnc_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cal_ff   <= 1'b1;
         min_x_ff <= {1'b0, {(SB-1){1'b1}}};
         min_y_ff <= {1'b0, {(SB-1){1'b1}}};
         max_x_ff <= {1'b1, {(SB-1){1'b0}}};
         max_y_ff <= {1'b1, {(SB-1){1'b0}}};
         off_ff   <= '0;
         decl_ff  <= DECL_RESET;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cal_ff   <= cal_in;
         min_x_ff <= min_x_in;
         min_y_ff <= min_y_in;
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
         off_ff   <= off_in;
         if (csr_wr_en) decl_ff <= csr_wr_data;
         rv_ff    <= rv_in;
      end
      action_ff <= action_in;
      cnt_ff    <= cnt_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      mc_x_ff   <= mc_x_in;
      mc_y_ff   <= mc_y_in;
      mp_x_ff   <= mp_x_in;
      mp_y_ff   <= mp_y_in;
      ang_ff    <= ang_in;
      raw_ff    <= raw_in;
      h_ff      <= h_in;
      hv_ff     <= hv_in;
      rhv_ff    <= rhv_in;
      rhdg_ff   <= rhdg_in;
      rsec_ff   <= rsec_in;
      rnc_ff    <= rnc_in;
   end

endmodule

// ----- hw/rtl/mch_cordic.sv -----
module mch_cordic
   import mch_pkg::*;
#(
   parameter int PW    = 43,
   parameter int CW    = 54,
   parameter int STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [PW-1:0]  px,
   input  logic signed [PW-1:0]  py,
   output logic                  done,
   output logic [ANGLE_W-1:0]    angle
);

   localparam int SW = $clog2(STEPS);
   localparam logic [CW-1:0] LIMIT =
      {{(CW-NORM_BIT-1){1'b0}}, 1'b1, {NORM_BIT{1'b0}}};

   cordic_state_type     state_ff, state_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic [ANGLE_W-1:0]   z_ff, z_in;
   logic [SW-1:0]        step_ff, step_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        abs_x, abs_y;
   logic signed [CW-1:0] dx, dy;
   logic                 big;

   assign done  = done_ff;
   assign angle = z_ff;

   always_comb begin
      abs_x = x_ff[CW-1] ? CW'(-x_ff) : CW'(x_ff);
      abs_y = y_ff[CW-1] ? CW'(-y_ff) : CW'(y_ff);
      big   = (abs_x >= LIMIT) || (abs_y >= LIMIT);
      dx    = y_ff >>> step_ff;
      dy    = x_ff >>> step_ff;

      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = CW'(px);
               y_in     = CW'(py);
               z_in     = '0;
               state_in = C_NORM;
            end
         end
         // one left shift per cycle until the larger axis is big enough
         C_NORM: begin
            if (big) begin
               step_in  = '0;
               state_in = C_ROT;
               if (x_ff[CW-1]) begin
                  x_in = -x_ff;
                  y_in = -y_ff;
                  z_in = {1'b1, {(ANGLE_W-1){1'b0}}};
               end
            end else begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end
         end
         // one vectoring micro-rotation per cycle
         C_ROT: begin
            if (!y_ff[CW-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_step(5'(step_ff));
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_step(5'(step_ff));
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(STEPS-1)) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

endmodule

// ----- hw/rtl/mch_checker.sv -----
`include "magnetometer_compass_heading_macros.svh"

module mch_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               heading_valid,
   input logic [15:0]        heading,
   input logic [1:0]         sector,
   input logic signed [15:0] north_correction
);

   // stalled response keeps its heading and sector
   `MCH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(heading) && $stable(sector))
   // heading stays within one turn
   `MCH_NEVER(a_hdg_range, clock, reset, rsp_valid && heading_valid && heading > 16'd35999)
   // calibration responses carry a zero heading
   `MCH_NEVER(a_cal_zero, clock, reset, rsp_valid && !heading_valid && (heading != 16'd0 || sector != 2'd0))
   // north sector wraps around zero degrees
   `MCH_NEVER(a_north_sec, clock, reset, rsp_valid && heading_valid && (heading < 16'd4500 || heading >= 16'd31500) && sector != 2'd0)
   // stored north offset stays inside a half turn
   `MCH_NEVER(a_nc_range, clock, reset, rsp_valid && (north_correction < -16'sd17999 || north_correction > 16'sd18000))

endmodule

bind magnetometer_compass_heading mch_checker u_mch_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .heading_valid    (rsp_chan.heading_valid),
   .heading          (rsp_chan.heading),
   .sector           (rsp_chan.sector),
   .north_correction (rsp_chan.north_correction)
);

// ----- tb/sv/compass_checker.sv -----
// Watches the request, response and register ports, predicts each heading
// response and compares it field by field with what the block returns.
module compass_checker
   import mch_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   mch_req_if                 req_mon,
   mch_rsp_if                 rsp_mon,
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data,
   output int                 fail_count,
   output int                 pending
);

   localparam int CORDIC_STEPS = 16;
   localparam longint NORM_FLOOR = 64'sd1 <<< NORM_BIT;

   typedef struct packed {
      logic               heading_valid;
      logic [15:0]        heading;
      logic [1:0]         sector;
      logic signed [15:0] north_correction;
   } heading_result;

   heading_result heading_queue[$];

   // predictor state
   logic cal_active;
   int   lo_x, lo_y, hi_x, hi_y;
   int   north_ofs;
   int   decl;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // binary angle of (px, py) from +px towards +py, 2^32 per turn
   function automatic logic [31:0] vector_angle(input longint px, input longint py);
      longint ax, ay, m, dx, dy;
      logic [31:0] z;
      z  = '0;
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;
      m  = (ax > ay) ? ax : ay;
      if (m == 0) return '0;
      while (m < NORM_FLOOR) begin
         px = px * 2;
         py = py * 2;
         m  = m * 2;
      end
      if (px < 0) begin
         px = -px;
         py = -py;
         z  = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px = px + dx;
            py = py - dy;
            z  = z + atan_step(5'(i));
         end else begin
            px = px - dx;
            py = py + dy;
            z  = z - atan_step(5'(i));
         end
      end
      return z;
   endfunction

   function automatic longint axis_span(input int lo, input int hi);
      longint s;
      s = longint'(hi) - longint'(lo);
      return (s > 0) ? s : 1;
   endfunction

   // advances the predictor by one request and returns its response
   task automatic predict_heading(input action_type act, input int mx, input int my,
                                  output heading_result r);
      longint cx, cy, bx, by;
      longint unsigned prod;
      logic [31:0] ang;
      int raw, h, off;
      r = '0;
      if (cal_active) begin
         if (mx < lo_x) lo_x = mx;
         if (my < lo_y) lo_y = my;
         if (mx > hi_x) hi_x = mx;
         if (my > hi_y) hi_y = my;
         if (act != ACT_SAMPLE) cal_active = 1'b0;
      end else begin
         cx   = 2 * longint'(mx) - (longint'(hi_x) + longint'(lo_x));
         cy   = 2 * longint'(my) - (longint'(hi_y) + longint'(lo_y));
         bx   = cx * axis_span(lo_y, hi_y);
         by   = cy * axis_span(lo_x, hi_x);
         ang  = vector_angle(by, bx);
         prod = {32'd0, ang} * 64'd36000 + 64'h8000_0000;
         raw  = int'(prod >> 32);
         if (raw >= FULL_TURN) raw -= FULL_TURN;
         h = (raw + decl + north_ofs) % FULL_TURN;
         if (h < 0) h += FULL_TURN;
         r.heading_valid = 1'b1;
         r.heading       = 16'(h);
         r.sector        = 2'(((h + EIGHTH_TURN) / QUARTER_TURN) % 4);
         if (act == ACT_SET_NORTH) begin
            off = -h;
            if (off <= -HALF_TURN) off += FULL_TURN;
            north_ofs = off;
         end else if (act == ACT_RESET_NORTH) begin
            north_ofs = 0;
         end
      end
      r.north_correction = 16'(north_ofs);
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      heading_result want;
      heading_result got;
      if (reset) begin
         cal_active = 1'b1;
         lo_x = 524287;
         lo_y = 524287;
         hi_x = -524288;
         hi_y = -524288;
         north_ofs = 0;
         decl = int'(DECL_RESET);
         heading_queue.delete();
      end else begin
         if (csr_wr_en) decl = int'(csr_wr_data);
         // request accepted: predict
         if (req_mon.valid && req_mon.ready) begin
            predict_heading(action_type'(req_mon.action), int'(req_mon.mag_x),
                            int'(req_mon.mag_y), want);
            heading_queue.push_back(want);
         end
         // response accepted: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.heading_valid    = rsp_mon.heading_valid;
            got.heading          = rsp_mon.heading;
            got.sector           = rsp_mon.sector;
            got.north_correction = rsp_mon.north_correction;
            if (heading_queue.size() == 0) begin
               report("unexpected response, heading", int'(got.heading), -1);
            end else begin
               want = heading_queue.pop_front();
               if (got.heading_valid !== want.heading_valid)
                  report("heading_valid", int'(got.heading_valid),
                         int'(want.heading_valid));
               if (got.heading !== want.heading)
                  report("heading", int'(got.heading), int'(want.heading));
               if (got.sector !== want.sector)
                  report("sector", int'(got.sector), int'(want.sector));
               if (got.north_correction !== want.north_correction)
                  report("north_correction", int'(got.north_correction),
                         int'(want.north_correction));
            end
         end
      end
      pending <= heading_queue.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Drives requests, register writes and response back-pressure; gives the verdict.
module tb_top;
   import mch_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic signed [15:0] csr_wr_data;
   int                 fail_count;
   int                 pending;
   int                 cycles;
   int                 stall_mode;

   mch_req_if #(.SAMPLE_BITS(20)) req_bus();
   mch_rsp_if                     rsp_bus();

   magnetometer_compass_heading #(.SAMPLE_BITS(20), .CORDIC_STEPS(16)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   compass_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response back-pressure, mode changes now and then
   initial stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // present one request and hold it until accepted
   task automatic send_request(input action_type act, input int mx, input int my);
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.mag_x  <= 20'(mx);
      req_bus.mag_y  <= 20'(my);
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic idle_gap(input int n);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain;
      idle_gap(0);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_declination(input int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 16'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic action_type pick_action;
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return ACT_SAMPLE;
      if (r < 80) return ACT_END_CAL;
      if (r < 90) return ACT_SET_NORTH;
      return ACT_RESET_NORTH;
   endfunction

   // random requests in bursts; mostly inside the calibrated box
   task automatic random_phase(input int count, input bit hold_off);
      int burst;
      int sent;
      int mx, my;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               mx = int'($signed(20'($urandom)));
               my = int'($signed(20'($urandom)));
            end else begin
               mx = $urandom_range(0, 1048574) - 524288;
               my = $urandom_range(0, 600000) - 300000;
            end
            send_request(pick_action(), mx, my);
            sent++;
         end
         if (hold_off && sent >= count / 2) begin
            // let everything outstanding come back before going on
            idle_gap(0);
            while (pending != 0) @(negedge clock);
            hold_off = 1'b0;
         end else if ($urandom_range(0, 2) != 0) begin
            idle_gap($urandom_range(0, 30));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_SAMPLE;
      req_bus.mag_x  = '0;
      req_bus.mag_y  = '0;
      rsp_bus.ready  = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_declination(-18000);

      // calibration box: x -524288..524286, y -300000..300000
      send_request(ACT_SAMPLE, -524288, -300000);
      send_request(ACT_SAMPLE, 524286, 300000);
      send_request(ACT_SAMPLE, 0, 0);
      // set-north while calibrating only ends calibration
      send_request(ACT_SET_NORTH, 100, -100);
      // sample exactly at the center: zero vector
      send_request(ACT_SAMPLE, -1, 0);
      send_request(ACT_SAMPLE, 524287, 0);
      send_request(ACT_SAMPLE, -524288, 0);
      send_request(ACT_SAMPLE, -1, 524287);
      send_request(ACT_SAMPLE, -1, -524288);
      send_request(ACT_SAMPLE, 524287, -524288);
      send_request(ACT_SAMPLE, -524288, 524287);
      send_request(ACT_SET_NORTH, 1000, 200000);
      send_request(ACT_SAMPLE, 300000, -150000);
      send_request(ACT_END_CAL, -250000, 120000);
      send_request(ACT_RESET_NORTH, 77, -77);
      send_request(ACT_SET_NORTH, -1, -200000);
      send_request(ACT_SAMPLE, 12345, 54321);
      send_request(ACT_SET_NORTH, -400000, 10);
      send_request(ACT_SAMPLE, 0, 0);
      drain();

      write_declination(18000);
      random_phase(400, 1'b1);
      drain();
      write_declination(0);
      random_phase(400, 1'b0);
      drain();
      write_declination(int'(DECL_RESET));
      random_phase(350, 1'b0);
      drain();
      write_declination($urandom_range(0, 36000) - 18000);
      random_phase(350, 1'b0);

      drain();
      repeat (120) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
